// ===== sv/ida_pkg.sv =====
// ----------------------------------------------------------------------------
// ida_pkg: shared types and constants of the identifier range allocator
// Request and response payloads, request kinds, status codes and widths.
// ----------------------------------------------------------------------------
package ida_pkg;

	localparam int ID_COUNT_DEF      = 256;
	localparam int PAYLOAD_WIDTH_DEF = 32;

	// one used-map row holds this many identifiers
	localparam int ROW_BITS = 8;
	// width of min_id / max_id and of the cursor
	localparam int BOUND_W  = 9;
	// scan row counter, one bit above the largest row of a 9-bit bound
	localparam int SROW_W   = 7;
	localparam int GID_W    = 17;
	localparam int BASE_W   = 16;
	localparam int PIN_W    = 32;

	typedef enum logic [1:0] {
		REQ_RANGE  = 2'd0,
		REQ_CYCLIC = 2'd1,
		REQ_FREE   = 2'd2,
		REQ_FIND   = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_USED = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t          req_type;
		logic [BOUND_W-1:0] min_id;
		logic [BOUND_W-1:0] max_id;
		logic [GID_W-1:0]   given_id;
		logic [PIN_W-1:0]   payload_in;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [GID_W-1:0] result_id;
		logic [PIN_W-1:0] payload_out;
	} rsp_t;

endpackage

// ===== sv/id_range_allocator_top.sv =====
// ----------------------------------------------------------------------------
// id_range_allocator_top: identifier allocator with range and cyclic search
// Scans the used map one 8-bit row per cycle; stores a payload per id.
// ----------------------------------------------------------------------------
// A cyclic allocation that finds no free id from the cursor retries once from
// min_id; an empty range or a full window answers ST_FULL.
// One request in work at a time: req_stall stays high until the result is
// registered on rsp, also while a previous response is still stalled.
// Reset sweeps every used-map row clear with req_stall high; id_base and the
// cursor reset to zero.
module id_range_allocator_top #(
	parameter int ID_COUNT      = ida_pkg::ID_COUNT_DEF,
	parameter int PAYLOAD_WIDTH = ida_pkg::PAYLOAD_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ida_pkg::req_t              req,
	input  logic                       req_valid,
	output logic                       req_stall,
	output ida_pkg::rsp_t              rsp,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic                       cfg_we,
	input  logic [ida_pkg::BASE_W-1:0] cfg_wdata
);

	localparam int ROWS = (ID_COUNT + ida_pkg::ROW_BITS - 1) / ida_pkg::ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int IW   = $clog2(ID_COUNT);
	localparam logic [17:0] IDC18 = 18'(ID_COUNT);

	typedef enum logic [2:0] {
		S_IDLE, S_PREP, S_INIT, S_SCAN, S_COMMIT, S_LOOK, S_LCHK, S_RESULT
	} state_t;

	state_t                        state_q;
	ida_pkg::req_t                 req_q;
	ida_pkg::rsp_t                 res_q;
	ida_pkg::rsp_t                 rsp_q;
	logic                          rsp_valid_q;
	logic [ida_pkg::BASE_W-1:0]    base_q;
	logic [ida_pkg::BOUND_W-1:0]   cursor_q;
	logic                          pass_q;
	logic [ida_pkg::BOUND_W-1:0]   start_q;
	logic [ida_pkg::BOUND_W-1:0]   lim_q;
	logic [ida_pkg::SROW_W-1:0]    first_row_q;
	logic [ida_pkg::SROW_W-1:0]    last_row_q;
	logic [ida_pkg::SROW_W-1:0]    scan_row_q;
	logic [2:0]                    s_bit_q;
	logic [2:0]                    l_bit_q;
	logic                          chk_v_q;
	logic [ida_pkg::SROW_W-1:0]    chk_row_q;
	logic [ida_pkg::BOUND_W-1:0]   hit_id_q;
	logic [ida_pkg::ROW_BITS-1:0]  row_new_q;
	logic [IW-1:0]                 u_q;
	logic                          foreign_q;

	logic [ida_pkg::BOUND_W-1:0]   lo9;
	logic [ida_pkg::BOUND_W-1:0]   hi9;
	logic [ida_pkg::BOUND_W-1:0]   cur_lo;
	logic [ida_pkg::BOUND_W-1:0]   cur_cl;
	logic [ida_pkg::BOUND_W-1:0]   s9;
	logic [ida_pkg::BOUND_W-1:0]   lm1;
	logic [17:0]                   diff18;
	logic [IW+RW+2:0]              u_ext;
	logic [RW-1:0]                 u_row;
	logic [2:0]                    u_bit;
	logic [RW+ida_pkg::SROW_W-1:0] sr_ext;
	logic [RW+ida_pkg::SROW_W-2:0] hr_ext;
	logic [IW+ida_pkg::BOUND_W-1:0] hi_ext;
	logic                          is_alloc;
	logic                          is_cyclic;
	logic                          clearing;
	logic                          issue;
	logic                          rp_hit;
	logic [2:0]                    rp_idx;
	logic                          pick_hit;
	logic                          used_bit;
	logic [RW-1:0]                 used_rd_row;
	logic [ida_pkg::ROW_BITS-1:0]  used_rd_data;
	logic                          used_wr_en;
	logic [RW-1:0]                 used_wr_row;
	logic [ida_pkg::ROW_BITS-1:0]  used_wr_data;
	logic                          pay_wr_en;
	logic [PAYLOAD_WIDTH+31:0]     pi_ext;
	logic [PAYLOAD_WIDTH-1:0]      pay_rd;
	logic [PAYLOAD_WIDTH+31:0]     pr_ext;
	logic [ida_pkg::GID_W-1:0]     alloc_rid;

	assign lo9       = req_q.min_id;
	assign hi9       = req_q.max_id;
	assign is_alloc  = (req_q.req_type == ida_pkg::REQ_RANGE)
		|| (req_q.req_type == ida_pkg::REQ_CYCLIC);
	assign is_cyclic = (req_q.req_type == ida_pkg::REQ_CYCLIC);

	// cursor clamped to the low bound first, then to the high bound
	assign cur_lo = (cursor_q < lo9) ? lo9 : cursor_q;
	assign cur_cl = (cur_lo > hi9) ? hi9 : cur_lo;

	assign s9  = (start_q == '0) ? 9'd1 : start_q;
	assign lm1 = lim_q - 9'd1;

	assign diff18 = {1'b0, req_q.given_id} - {2'b00, base_q};

	assign u_ext = (IW + RW + 3)'(u_q);
	assign u_row = u_ext[RW+2:3];
	assign u_bit = u_ext[2:0];

	assign sr_ext = (RW + ida_pkg::SROW_W)'(scan_row_q);
	assign hr_ext = (RW + ida_pkg::SROW_W - 1)'(hit_id_q[8:3]);
	assign hi_ext = (IW + ida_pkg::BOUND_W)'(hit_id_q);

	assign issue    = (state_q == S_SCAN) && (scan_row_q <= last_row_q) && !pick_hit;
	assign pick_hit = chk_v_q && rp_hit;
	assign used_bit = used_rd_data[u_bit];

	assign used_rd_row  = (state_q == S_LOOK) ? u_row : sr_ext[RW-1:0];
	assign used_wr_en   = (state_q == S_COMMIT)
		|| ((state_q == S_LCHK) && (req_q.req_type == ida_pkg::REQ_FREE) && used_bit);
	assign used_wr_row  = (state_q == S_COMMIT) ? hr_ext[RW-1:0] : u_row;
	assign used_wr_data = (state_q == S_COMMIT) ? row_new_q
		: (used_rd_data & ~(8'd1 << u_bit));

	assign pay_wr_en = (state_q == S_COMMIT);
	assign pi_ext    = {{PAYLOAD_WIDTH{1'b0}}, req_q.payload_in};
	assign pr_ext    = {32'd0, pay_rd};

	assign alloc_rid = {8'd0, hit_id_q} + {1'b0, base_q};

	ida_row_pick u_pick (
		.row_data  (used_rd_data),
		.row       (chk_row_q),
		.first_row (first_row_q),
		.last_row  (last_row_q),
		.s_bit     (s_bit_q),
		.l_bit     (l_bit_q),
		.hit       (rp_hit),
		.bit_idx   (rp_idx)
	);

	ida_used_map #(
		.ROWS (ROWS),
		.RW   (RW)
	) u_used (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_row   (used_rd_row),
		.rd_data  (used_rd_data),
		.wr_en    (used_wr_en),
		.wr_row   (used_wr_row),
		.wr_data  (used_wr_data),
		.clearing (clearing)
	);

	ida_pay_mem #(
		.DEPTH (ID_COUNT),
		.AW    (IW),
		.W     (PAYLOAD_WIDTH)
	) u_pay (
		.clk     (clk),
		.wr_en   (pay_wr_en),
		.wr_addr (hi_ext[IW-1:0]),
		.wr_data (pi_ext[PAYLOAD_WIDTH-1:0]),
		.rd_addr (u_q),
		.rd_data (pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			base_q      <= '0;
			cursor_q    <= '0;
			pass_q      <= 1'b0;
			start_q     <= '0;
			lim_q       <= '0;
			first_row_q <= '0;
			last_row_q  <= '0;
			scan_row_q  <= '0;
			s_bit_q     <= '0;
			l_bit_q     <= '0;
			chk_v_q     <= 1'b0;
			chk_row_q   <= '0;
			hit_id_q    <= '0;
			row_new_q   <= '0;
			u_q         <= '0;
			foreign_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				base_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall && (state_q != S_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end

			// read data of the row issued now is checked next cycle
			chk_v_q <= issue;
			if (issue) begin
				chk_row_q  <= scan_row_q;
				scan_row_q <= scan_row_q + 7'd1;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						req_q   <= req;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					pass_q    <= 1'b0;
					lim_q     <= ({9'd0, hi9} > IDC18) ? IDC18[8:0] : hi9;
					start_q   <= is_cyclic ? cur_cl : lo9;
					u_q       <= diff18[IW-1:0];
					foreign_q <= (diff18 >= IDC18);
					state_q   <= is_alloc ? S_INIT : S_LOOK;
				end
				S_INIT: begin
					if (s9 >= lim_q) begin
						if (is_cyclic && !pass_q) begin
							pass_q  <= 1'b1;
							start_q <= lo9;
						end else begin
							res_q   <= '{ida_pkg::ST_FULL, '0, '0};
							state_q <= S_RESULT;
						end
					end else begin
						first_row_q <= {1'b0, s9[8:3]};
						scan_row_q  <= {1'b0, s9[8:3]};
						last_row_q  <= {1'b0, lm1[8:3]};
						s_bit_q     <= s9[2:0];
						l_bit_q     <= lm1[2:0];
						state_q     <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pick_hit) begin
						hit_id_q  <= {chk_row_q[5:0], rp_idx};
						row_new_q <= used_rd_data | (8'd1 << rp_idx);
						state_q   <= S_COMMIT;
					end else if (!issue && !chk_v_q) begin
						// window exhausted: cyclic retries from min_id
						if (is_cyclic && !pass_q) begin
							pass_q  <= 1'b1;
							start_q <= lo9;
							state_q <= S_INIT;
						end else begin
							res_q   <= '{ida_pkg::ST_FULL, '0, '0};
							state_q <= S_RESULT;
						end
					end
				end
				S_COMMIT: begin
					if (is_cyclic) begin
						cursor_q <= hit_id_q + 9'd1;
					end
					res_q   <= '{ida_pkg::ST_OK, alloc_rid, '0};
					state_q <= S_RESULT;
				end
				S_LOOK: begin
					if (foreign_q) begin
						res_q   <= '{ida_pkg::ST_NOT_USED, '0, '0};
						state_q <= S_RESULT;
					end else begin
						state_q <= S_LCHK;
					end
				end
				S_LCHK: begin
					if (used_bit) begin
						res_q <= '{ida_pkg::ST_OK, '0, pr_ext[31:0]};
					end else begin
						res_q <= '{ida_pkg::ST_NOT_USED, '0, '0};
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= res_q;
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE) || clearing;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ===== sv/ida_row_pick.sv =====
// ----------------------------------------------------------------------------
// ida_row_pick: lowest free identifier in one used-map row
// Masks the row to the search window and returns the first clear bit.
// ----------------------------------------------------------------------------
module ida_row_pick (
	input  logic [ida_pkg::ROW_BITS-1:0] row_data,
	input  logic [ida_pkg::SROW_W-1:0]   row,
	input  logic [ida_pkg::SROW_W-1:0]   first_row,
	input  logic [ida_pkg::SROW_W-1:0]   last_row,
	input  logic [2:0]                   s_bit,
	input  logic [2:0]                   l_bit,
	output logic                         hit,
	output logic [2:0]                   bit_idx
);

	logic [ida_pkg::ROW_BITS-1:0] cand;

	always_comb begin
		for (int j = 0; j < ida_pkg::ROW_BITS; j++) begin
			cand[j] = !row_data[j]
				&& ((row != first_row) || (3'(j) >= s_bit))
				&& ((row != last_row) || (3'(j) <= l_bit));
		end
	end

	always_comb begin
		bit_idx = 3'd0;
		for (int j = ida_pkg::ROW_BITS - 1; j >= 0; j--) begin
			if (cand[j]) begin
				bit_idx = 3'(j);
			end
		end
	end

	assign hit = |cand;

endmodule

// ===== sv/ida_used_map.sv =====
// ----------------------------------------------------------------------------
// ida_used_map: used map of identifiers, one row of bits per word
// Registered read, one write port, clearing sweep after reset.
// ----------------------------------------------------------------------------
module ida_used_map #(
	parameter int ROWS = 32,
	parameter int RW   = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [RW-1:0]                rd_row,
	output logic [ida_pkg::ROW_BITS-1:0] rd_data,
	input  logic                         wr_en,
	input  logic [RW-1:0]                wr_row,
	input  logic [ida_pkg::ROW_BITS-1:0] wr_data,
	output logic                         clearing
);

	logic [ida_pkg::ROW_BITS-1:0] mem [ROWS];
	logic [ida_pkg::ROW_BITS-1:0] rd_data_q;
	logic [RW-1:0]                clr_row_q;
	logic                         clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clearing_q) begin
			clr_row_q <= clr_row_q + RW'(1);
			if (clr_row_q == RW'(ROWS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_row_q] <= '0;
		end else if (wr_en) begin
			mem[wr_row] <= wr_data;
		end
		rd_data_q <= mem[rd_row];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== sv/ida_pay_mem.sv =====
// ----------------------------------------------------------------------------
// ida_pay_mem: payload word per identifier
// Single write port, registered read.
// ----------------------------------------------------------------------------
module ida_pay_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
